>>> rtl/rre_pkg.sv
`timescale 1ns / 1ps

package rre_pkg;

   // Field and datapath widths.
   localparam int ANGLE_BITS   = 16;
   localparam int COORD_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int CELL_BITS    = 8;
   localparam int FRAC_BITS    = 16;
   localparam int SCALE_BITS   = 8;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DAT_BITS = 16;

   // Angle constants in heading units.
   localparam int HALF_TURN    = 1 << (ANGLE_BITS - 1);
   localparam int QUARTER_TURN = 1 << (ANGLE_BITS - 2);

   // The rotator works in units of 2^-32 turn on a vector that starts at 2^28.
   localparam int TURN_BITS   = 32;
   localparam int CORDIC_ONE  = 28;
   localparam int CORDIC_W    = CORDIC_ONE + 3;
   localparam int ZW          = TURN_BITS + 2;
   localparam int MAG_W       = CORDIC_ONE + 2;
   localparam int TABLE_LEN   = 24;

   // Quotients are only needed up to a bound past any coordinate.
   localparam int QBITS       = COORD_BITS + 2;
   localparam int NUM_W       = COORD_BITS + MAG_W;
   localparam int DIV_LAT     = QBITS + 1;

   // Register indexes on the write port.
   localparam logic [CSR_IDX_BITS-1:0] REG_CELL_SCALE  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_LEFT_EDGE   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_RIGHT_EDGE  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_TOP_EDGE    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_BOTTOM_EDGE = 3'd4;

   // Kind of ray: the four straight headings and everything else.
   typedef enum logic [2:0] {
      DIR_NORTH = 3'd0,
      DIR_SOUTH = 3'd1,
      DIR_WEST  = 3'd2,
      DIR_EAST  = 3'd3,
      DIR_SLANT = 3'd4
   } dir_type;

   // Per-item data that rides along with the rotator and the dividers.
   typedef struct packed {
      logic [COORD_BITS-1:0] bx;
      logic [COORD_BITS-1:0] by;
      dir_type               dir;
      logic                  upper;
      logic                  east;
   } side_type;

   typedef struct packed {
      side_type side;
      logic     yneg;
      logic     xneg;
   } side2_type;

   // atan(2^-i) in units of 2^-32 turn.
   function automatic logic [TURN_BITS-1:0] atan_at(input int i);
      logic [TURN_BITS-1:0] r;
      unique case (i)
         0:  r = 32'd536870912;
         1:  r = 32'd316933406;
         2:  r = 32'd167458907;
         3:  r = 32'd85004756;
         4:  r = 32'd42667331;
         5:  r = 32'd21354465;
         6:  r = 32'd10679838;
         7:  r = 32'd5340245;
         8:  r = 32'd2670163;
         9:  r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/rre_cordic.sv
`timescale 1ns / 1ps

module rre_cordic (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [rre_pkg::ZW-1:0]       angle,
   output logic        [rre_pkg::MAG_W-1:0]    cos_mag,
   output logic        [rre_pkg::MAG_W-1:0]    sin_mag
);

   localparam int N  = rre_pkg::CORDIC_STEPS;
   localparam int CW = rre_pkg::CORDIC_W;
   localparam int ZW = rre_pkg::ZW;

   logic signed [CW-1:0] x_ff [N];
   logic signed [CW-1:0] y_ff [N];
   logic signed [ZW-1:0] z_ff [N];

   // One rotation step per register stage.
   for (genvar k = 0; k < N; k++) begin : g_step
      logic signed [CW-1:0] xs, ys, x_in, y_in;
      logic signed [ZW-1:0] zs, z_in;
      logic signed [ZW-1:0] step;

      if (k == 0) begin : g_first
         assign xs = CW'(1) <<< rre_pkg::CORDIC_ONE;
         assign ys = '0;
         assign zs = angle;
      end else begin : g_next
         assign xs = x_ff[k-1];
         assign ys = y_ff[k-1];
         assign zs = z_ff[k-1];
      end

      assign step = $signed(ZW'(rre_pkg::atan_at(k)));

      always_comb begin
         if (zs >= 0) begin
            x_in = xs - (ys >>> k);
            y_in = ys + (xs >>> k);
            z_in = zs - step;
         end else begin
            x_in = xs + (ys >>> k);
            y_in = ys - (xs >>> k);
            z_in = zs + step;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[k] <= x_in;
            y_ff[k] <= y_in;
            z_ff[k] <= z_in;
         end
      end
   end

   // Negative results count as zero.
   assign cos_mag = x_ff[N-1][CW-1] ? '0 : x_ff[N-1][rre_pkg::MAG_W-1:0];
   assign sin_mag = y_ff[N-1][CW-1] ? '0 : y_ff[N-1][rre_pkg::MAG_W-1:0];

endmodule

>>> rtl/rre_divider.sv
`timescale 1ns / 1ps

module rre_divider (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [rre_pkg::NUM_W-1:0]       num,
   input  logic [rre_pkg::MAG_W-1:0]       den,
   output logic [rre_pkg::QBITS:0]         quot
);

   localparam int QB = rre_pkg::QBITS;
   localparam int MW = rre_pkg::MAG_W;
   localparam int NW = rre_pkg::NUM_W;

   logic [MW-1:0] rem_ff [QB+1];
   logic [QB-1:0] low_ff [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic [MW-1:0] den_ff [QB+1];
   logic          ovf_ff [QB+1];

   logic          ovf_in;
   logic [MW-1:0] den_in;

   // Quotients at or past the bound saturate; a zero divisor saturates too
   // unless the dividend is zero, which gives zero.
   always_comb begin
      if (den == '0) begin
         ovf_in = (num != '0);
         den_in = MW'(1);
      end else begin
         ovf_in = ((MW + QB)'(num) >= {den, {QB{1'b0}}});
         den_in = den;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= MW'(num >> QB);
         low_ff[0] <= num[QB-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den_in;
         ovf_ff[0] <= ovf_in;
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar k = 0; k < QB; k++) begin : g_bit
      logic [MW:0] trial;
      logic        ge;

      assign trial = {rem_ff[k], low_ff[k][QB-1]};
      assign ge    = (trial >= {1'b0, den_ff[k]});

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= ge ? MW'(trial - {1'b0, den_ff[k]}) : trial[MW-1:0];
            low_ff[k+1] <= {low_ff[k][QB-2:0], 1'b0};
            q_ff[k+1]   <= {q_ff[k][QB-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign quot = ovf_ff[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_ff[QB]};

endmodule

>>> rtl/ray_rectangle_exit_point.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle unless a result is stalled; the
// 16-step rotator and the two 18-bit dividers are fully pipelined,
// one step or quotient bit per stage. A stalled result holds the
// whole pipeline in place.
// Reset is synchronous, clears all valid bits and loads register defaults.
module ray_rectangle_exit_point (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [rre_pkg::CELL_BITS-1:0]         req_cell_x,
   input  logic [rre_pkg::CELL_BITS-1:0]         req_cell_y,
   input  logic [rre_pkg::FRAC_BITS-1:0]         req_offset_x,
   input  logic [rre_pkg::FRAC_BITS-1:0]         req_offset_y,
   input  logic signed [rre_pkg::ANGLE_BITS-1:0] req_heading,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rre_pkg::COORD_BITS-1:0]        rsp_start_x,
   output logic [rre_pkg::COORD_BITS-1:0]        rsp_start_y,
   output logic [rre_pkg::COORD_BITS-1:0]        rsp_end_x,
   output logic [rre_pkg::COORD_BITS-1:0]        rsp_end_y,
   input  logic                                  csr_write,
   input  logic [rre_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rre_pkg::CSR_DAT_BITS-1:0]      csr_data
);

   localparam int CB = rre_pkg::COORD_BITS;
   localparam int AB = rre_pkg::ANGLE_BITS;
   localparam int NC = rre_pkg::CORDIC_STEPS;
   localparam int ND = rre_pkg::DIV_LAT;
   localparam int QB = rre_pkg::QBITS;
   localparam int PW = rre_pkg::CELL_BITS + rre_pkg::FRAC_BITS + rre_pkg::SCALE_BITS;

   // Configuration registers.
   logic [rre_pkg::SCALE_BITS-1:0] scale_ff;
   logic [CB-1:0] left_ff, right_ff, top_ff, bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= rre_pkg::SCALE_BITS'(16);
         left_ff   <= '0;
         right_ff  <= CB'(255);
         top_ff    <= '0;
         bottom_ff <= CB'(255);
      end else if (csr_write) begin
         unique case (csr_index)
            rre_pkg::REG_CELL_SCALE:  scale_ff  <= csr_data[rre_pkg::SCALE_BITS-1:0];
            rre_pkg::REG_LEFT_EDGE:   left_ff   <= csr_data[CB-1:0];
            rre_pkg::REG_RIGHT_EDGE:  right_ff  <= csr_data[CB-1:0];
            rre_pkg::REG_TOP_EDGE:    top_ff    <= csr_data[CB-1:0];
            rre_pkg::REG_BOTTOM_EDGE: bottom_ff <= csr_data[CB-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves unless a result waits on a stalled receiver.
   logic advance, accept;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // Stage 0: start point and heading fold.
   logic [PW-1:0]           fx, fy;
   logic [AB-1:0]           mag;
   logic [AB-1:0]           phi;
   rre_pkg::side_type       side0_in, side0_ff;
   logic signed [rre_pkg::ZW-1:0] angle_in, angle_ff;
   logic                    v0_ff;

   always_comb begin
      fx = PW'({req_cell_x, req_offset_x}) * PW'(scale_ff);
      fy = PW'({req_cell_y, req_offset_y}) * PW'(scale_ff);
      mag = req_heading[AB-1] ? AB'(-req_heading) : AB'(req_heading);
      side0_in.bx    = fx[rre_pkg::FRAC_BITS +: CB];
      side0_in.by    = fy[rre_pkg::FRAC_BITS +: CB];
      side0_in.upper = (mag < AB'(rre_pkg::QUARTER_TURN));
      side0_in.east  = !req_heading[AB-1];
      phi = side0_in.upper ? mag : AB'(rre_pkg::HALF_TURN) - mag;
      angle_in = $signed(rre_pkg::ZW'(phi) << (rre_pkg::TURN_BITS - AB));
      if (req_heading == '0)
         side0_in.dir = rre_pkg::DIR_NORTH;
      else if (req_heading == AB'(rre_pkg::HALF_TURN))
         side0_in.dir = rre_pkg::DIR_SOUTH;
      else if (req_heading == AB'(-rre_pkg::QUARTER_TURN))
         side0_in.dir = rre_pkg::DIR_WEST;
      else if (req_heading == AB'(rre_pkg::QUARTER_TURN))
         side0_in.dir = rre_pkg::DIR_EAST;
      else
         side0_in.dir = rre_pkg::DIR_SLANT;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v0_ff <= 1'b0;
      else if (advance)
         v0_ff <= accept;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side0_ff <= side0_in;
         angle_ff <= angle_in;
      end
   end

   // Rotator stages, with item data delayed alongside.
   logic [rre_pkg::MAG_W-1:0] mc, ms;
   rre_pkg::side_type         sidec_ff [NC];
   logic                      vc_ff    [NC];

   rre_cordic u_cordic (
      .clock   (clock),
      .enable  (advance),
      .angle   (angle_ff),
      .cos_mag (mc),
      .sin_mag (ms)
   );

   for (genvar k = 0; k < NC; k++) begin : g_cdly
      always_ff @(posedge clock) begin
         if (reset)
            vc_ff[k] <= 1'b0;
         else if (advance)
            vc_ff[k] <= (k == 0) ? v0_ff : vc_ff[(k == 0) ? 0 : k-1];
      end
      always_ff @(posedge clock) begin
         if (advance)
            sidec_ff[k] <= (k == 0) ? side0_ff : sidec_ff[(k == 0) ? 0 : k-1];
      end
   end

   // Product stage: distances to the edges times the rotated components.
   rre_pkg::side_type    sc;
   logic signed [CB:0]   ydist, xdist;
   logic [CB-1:0]        ymag, xmag;
   logic [rre_pkg::NUM_W-1:0] num1_ff, num2_ff;
   logic [rre_pkg::MAG_W-1:0] mc_ff, ms_ff;
   rre_pkg::side2_type   sidem_in, sidem_ff;
   logic                 vm_ff;

   assign sc = sidec_ff[NC-1];

   always_comb begin
      ydist = sc.upper ? $signed({1'b0, sc.by}) - $signed({1'b0, top_ff})
                       : $signed({1'b0, bottom_ff}) - $signed({1'b0, sc.by});
      xdist = sc.east  ? $signed({1'b0, right_ff}) - $signed({1'b0, sc.bx})
                       : $signed({1'b0, sc.bx}) - $signed({1'b0, left_ff});
      ymag = ydist[CB] ? CB'(-ydist) : ydist[CB-1:0];
      xmag = xdist[CB] ? CB'(-xdist) : xdist[CB-1:0];
      sidem_in.side = sc;
      sidem_in.yneg = ydist[CB];
      sidem_in.xneg = xdist[CB];
   end

   always_ff @(posedge clock) begin
      if (reset)
         vm_ff <= 1'b0;
      else if (advance)
         vm_ff <= vc_ff[NC-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num1_ff  <= rre_pkg::NUM_W'(ymag) * rre_pkg::NUM_W'(ms);
         num2_ff  <= rre_pkg::NUM_W'(xmag) * rre_pkg::NUM_W'(mc);
         mc_ff    <= mc;
         ms_ff    <= ms;
         sidem_ff <= sidem_in;
      end
   end

   // Two dividers: x on the y edge and y on the x edge.
   logic [QB:0]        q1, q2;
   rre_pkg::side2_type sided_ff [ND];
   logic               vd_ff    [ND];

   rre_divider u_div_x (
      .clock  (clock),
      .enable (advance),
      .num    (num1_ff),
      .den    (mc_ff),
      .quot   (q1)
   );

   rre_divider u_div_y (
      .clock  (clock),
      .enable (advance),
      .num    (num2_ff),
      .den    (ms_ff),
      .quot   (q2)
   );

   for (genvar k = 0; k < ND; k++) begin : g_ddly
      always_ff @(posedge clock) begin
         if (reset)
            vd_ff[k] <= 1'b0;
         else if (advance)
            vd_ff[k] <= (k == 0) ? vm_ff : vd_ff[(k == 0) ? 0 : k-1];
      end
      always_ff @(posedge clock) begin
         if (advance)
            sided_ff[k] <= (k == 0) ? sidem_ff : sided_ff[(k == 0) ? 0 : k-1];
      end
   end

   // Final stage: pick the edge and clamp.
   rre_pkg::side2_type    sd;
   logic signed [QB+1:0]  q1s, q2s;
   logic signed [QB+2:0]  xc, yc;
   logic                  x_inside;
   logic [CB-1:0]         ex_in, ey_in;
   logic [CB-1:0]         sx_ff, sy_ff, ex_ff, ey_ff;

   assign sd = sided_ff[ND-1];

   always_comb begin
      q1s = sd.yneg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
      q2s = sd.xneg ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
      xc  = $signed((QB+3)'({1'b0, sd.side.bx}))
          + (sd.side.east ? (QB+3)'(q1s) : -(QB+3)'(q1s));
      yc  = $signed((QB+3)'({1'b0, sd.side.by}))
          + (sd.side.upper ? -(QB+3)'(q2s) : (QB+3)'(q2s));
      x_inside = (xc >= $signed((QB+3)'({1'b0, left_ff})))
              && (xc <= $signed((QB+3)'({1'b0, right_ff})));
      if (yc > $signed((QB+3)'({1'b0, bottom_ff})))
         yc = $signed((QB+3)'({1'b0, bottom_ff}));
      if (yc < $signed((QB+3)'({1'b0, top_ff})))
         yc = $signed((QB+3)'({1'b0, top_ff}));
      ex_in = sd.side.bx;
      ey_in = sd.side.by;
      unique case (sd.side.dir)
         rre_pkg::DIR_NORTH: ey_in = top_ff;
         rre_pkg::DIR_SOUTH: ey_in = bottom_ff;
         rre_pkg::DIR_WEST:  ex_in = left_ff;
         rre_pkg::DIR_EAST:  ex_in = right_ff;
         default: begin
            if (x_inside) begin
               ex_in = xc[CB-1:0];
               ey_in = sd.side.upper ? top_ff : bottom_ff;
            end else begin
               ex_in = sd.side.east ? right_ff : left_ff;
               ey_in = yc[CB-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (advance)
         rsp_valid_ff <= vd_ff[ND-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sx_ff <= sd.side.bx;
         sy_ff <= sd.side.by;
         ex_ff <= ex_in;
         ey_ff <= ey_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_start_x = sx_ff;
   assign rsp_start_y = sy_ff;
   assign rsp_end_x   = ex_ff;
   assign rsp_end_y   = ey_ff;

endmodule

>>> rtl/rre_checker.sv
`timescale 1ns / 1ps

module rre_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [rre_pkg::CELL_BITS-1:0]         req_cell_x,
   input  logic [rre_pkg::CELL_BITS-1:0]         req_cell_y,
   input  logic [rre_pkg::FRAC_BITS-1:0]         req_offset_x,
   input  logic [rre_pkg::FRAC_BITS-1:0]         req_offset_y,
   input  logic signed [rre_pkg::ANGLE_BITS-1:0] req_heading,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [rre_pkg::COORD_BITS-1:0]        rsp_start_x,
   input  logic [rre_pkg::COORD_BITS-1:0]        rsp_start_y,
   input  logic [rre_pkg::COORD_BITS-1:0]        rsp_end_x,
   input  logic [rre_pkg::COORD_BITS-1:0]        rsp_end_y,
   input  logic                                  csr_write,
   input  logic [rre_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rre_pkg::CSR_DAT_BITS-1:0]      csr_data
);

   localparam int CB = rre_pkg::COORD_BITS;

   // Shadow copy of the rectangle, tracked from the write port.
   logic [CB-1:0] left_ff, right_ff, top_ff, bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= CB'(255);
         top_ff    <= '0;
         bottom_ff <= CB'(255);
      end else if (csr_write) begin
         unique case (csr_index)
            rre_pkg::REG_LEFT_EDGE:   left_ff   <= csr_data[CB-1:0];
            rre_pkg::REG_RIGHT_EDGE:  right_ff  <= csr_data[CB-1:0];
            rre_pkg::REG_TOP_EDGE:    top_ff    <= csr_data[CB-1:0];
            rre_pkg::REG_BOTTOM_EDGE: bottom_ff <= csr_data[CB-1:0];
            default: ;
         endcase
      end
   end

   // A stalled result stays and holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_end_x) && $stable(rsp_end_y)
         && $stable(rsp_start_x) && $stable(rsp_start_y))
      else $error("result changed while stalled");

   // Input is held back only by a waiting result.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // No result right after reset.
   a_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Every end point lies on a line of the rectangle border.
   a_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_x == left_ff) || (rsp_end_x == right_ff)
         || (rsp_end_y == top_ff) || (rsp_end_y == bottom_ff))
      else $error("end point off the border");

endmodule

bind ray_rectangle_exit_point rre_checker u_rre_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_cell_x = '0;
   logic [7:0]  req_cell_y = '0;
   logic [15:0] req_offset_x = '0;
   logic [15:0] req_offset_y = '0;
   logic signed [15:0] req_heading = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic        csr_write = 1'b0;
   logic [rre_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [rre_pkg::CSR_DAT_BITS-1:0] csr_data = '0;

   ray_rectangle_exit_point DUT (.*);

   // One query and the exit point it produces.
   typedef struct {
      logic [7:0]  cx, cy;
      logic [15:0] ox, oy;
      logic [15:0] hd;
   } query_type;

   typedef struct {
      logic [15:0] sx, sy, ex, ey;
   } exit_type;

   // Directed row: query, plus a typed-in answer where one is obvious.
   typedef struct {
      query_type q;
      bit        typed;
      exit_type  r;
   } row_type;

   localparam int LATENCY = 38;

   // Shadow copy of the registers.
   logic [7:0]  scale_q = 8'd16;
   logic [15:0] left_q = 16'd0, right_q = 16'd255, top_q = 16'd0, bottom_q = 16'd255;

   exit_type pending_exits[$];
   int    errors = 0;
   int    sent = 0;
   int    received = 0;
   int    cfg_phases = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Timeout: %0d sent, %0d received", sent, received);
      $display("FAILURE");
      $finish;
   end

   // Floor shift for the rotator.
   function automatic longint floor_shr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
   endfunction

   // Division that saturates on a zero divisor.
   function automatic longint clip_div(longint num, longint den);
      if (den == 0) return num > 0 ? (64'sd1 <<< 40) : (num < 0 ? -(64'sd1 <<< 40) : 0);
      return num / den;
   endfunction

   function automatic exit_type exit_point(query_type q);
      longint fx, fy, bx, by, h, ex, ey;
      longint lft, rgt, tp, bt;
      longint sgn, mag, phi, cx, cy, z, dx, dy, mc, ms, ydist, xdist, xx, yy;
      bit     upper;
      exit_type r;
      lft = longint'(left_q); rgt = longint'(right_q);
      tp = longint'(top_q); bt = longint'(bottom_q);
      fx = ((longint'(q.cx) << 16) | longint'(q.ox)) * longint'(scale_q);
      fy = ((longint'(q.cy) << 16) | longint'(q.oy)) * longint'(scale_q);
      bx = (fx >> 16) & 16'hFFFF;
      by = (fy >> 16) & 16'hFFFF;
      h = longint'($signed(q.hd));
      ex = bx; ey = by;
      if (h == 0) ey = tp;
      else if (h == -rre_pkg::HALF_TURN) ey = bt;
      else if (h == -rre_pkg::QUARTER_TURN) ex = lft;
      else if (h == rre_pkg::QUARTER_TURN) ex = rgt;
      else begin
         sgn = h > 0 ? 1 : -1;
         mag = h > 0 ? h : -h;
         upper = mag < rre_pkg::QUARTER_TURN;
         phi = upper ? mag : rre_pkg::HALF_TURN - mag;
         // Rotate (2^28, 0) by the folded angle.
         cx = 64'sd1 <<< 28; cy = 0; z = phi <<< 16;
         for (int i = 0; i < rre_pkg::CORDIC_STEPS; i++) begin
            dx = floor_shr(cy, i);
            dy = floor_shr(cx, i);
            if (z >= 0) begin
               cx -= dx; cy += dy; z -= longint'(rre_pkg::atan_at(i));
            end else begin
               cx += dx; cy -= dy; z += longint'(rre_pkg::atan_at(i));
            end
         end
         mc = cx < 0 ? 0 : cx;
         ms = cy < 0 ? 0 : cy;
         ydist = upper ? by - tp : bt - by;
         xx = bx + sgn * clip_div(ydist * ms, mc);
         if (xx >= lft && xx <= rgt) begin
            ex = xx;
            ey = upper ? tp : bt;
         end else begin
            xdist = sgn > 0 ? rgt - bx : bx - lft;
            yy = by + (upper ? -1 : 1) * clip_div(xdist * mc, ms);
            if (yy > bt) yy = bt;
            if (yy < tp) yy = tp;
            ex = sgn > 0 ? rgt : lft;
            ey = yy;
         end
      end
      r.sx = bx[15:0]; r.sy = by[15:0]; r.ex = ex[15:0]; r.ey = ey[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("Mismatch on result %0d: %s got %0d expected %0d", received, what, got, want);
   endtask

   // Result side: random stall pattern, compare each transfer.
   int stall_pct = 0;
   always @(posedge clock) begin
      exit_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            received++;
            if (pending_exits.size() == 0) begin
               errors++;
               $display("Unexpected result transfer %0d", received);
            end else begin
               w = pending_exits.pop_front();
               if (rsp_start_x !== w.sx) report_mismatch("start_x", rsp_start_x, w.sx);
               if (rsp_start_y !== w.sy) report_mismatch("start_y", rsp_start_y, w.sy);
               if (rsp_end_x !== w.ex) report_mismatch("end_x", rsp_end_x, w.ex);
               if (rsp_end_y !== w.ey) report_mismatch("end_y", rsp_end_y, w.ey);
            end
         end
         if ($urandom_range(99) < 3) stall_pct <= $urandom_range(3) * 25;
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic write_reg(logic [rre_pkg::CSR_IDX_BITS-1:0] idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         rre_pkg::REG_CELL_SCALE:  scale_q = val[7:0];
         rre_pkg::REG_LEFT_EDGE:   left_q = val;
         rre_pkg::REG_RIGHT_EDGE:  right_q = val;
         rre_pkg::REG_TOP_EDGE:    top_q = val;
         rre_pkg::REG_BOTTOM_EDGE: bottom_q = val;
         default: ;
      endcase
   endtask

   task automatic set_rect(logic [7:0] s, logic [15:0] l, logic [15:0] r,
                           logic [15:0] t, logic [15:0] b);
      write_reg(rre_pkg::REG_CELL_SCALE, {8'd0, s});
      write_reg(rre_pkg::REG_LEFT_EDGE, l);
      write_reg(rre_pkg::REG_RIGHT_EDGE, r);
      write_reg(rre_pkg::REG_TOP_EDGE, t);
      write_reg(rre_pkg::REG_BOTTOM_EDGE, b);
      cfg_phases++;
   endtask

   // Drive one query and hold it until the block takes it.
   task automatic send_query(query_type q, exit_type want);
      req_valid    <= 1'b1;
      req_cell_x   <= q.cx;
      req_cell_y   <= q.cy;
      req_offset_x <= q.ox;
      req_offset_y <= q.oy;
      req_heading  <= q.hd;
      pending_exits.push_back(want);
      sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Burst of back-to-back transfers, then a random gap.
   int burst_left = 0;
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(40);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_exits.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic query_type random_query();
      query_type q;
      q.cx = 8'($urandom); q.cy = 8'($urandom);
      q.ox = 16'($urandom); q.oy = 16'($urandom);
      case ($urandom_range(7))
         0: q.hd = 16'(int'($urandom_range(3)) * rre_pkg::QUARTER_TURN);
         1: q.hd = 16'(int'($urandom_range(3)) * rre_pkg::QUARTER_TURN
                       + int'($urandom_range(4)) - 2);
         default: q.hd = 16'($urandom);
      endcase
      // Keep the start often inside small rectangles.
      if ($urandom_range(1)) begin
         q.cx = 8'($urandom_range(15)); q.cy = 8'($urandom_range(15));
      end
      return q;
   endfunction

   // Directed table, written against the reset registers.
   row_type rows[$];
   function automatic row_type mk(logic [7:0] cx, logic [7:0] cy, logic [15:0] ox,
                                  logic [15:0] oy, logic [15:0] hd, bit typed,
                                  logic [15:0] sx = 0, logic [15:0] sy = 0,
                                  logic [15:0] ex = 0, logic [15:0] ey = 0);
      row_type r;
      r.q = '{cx, cy, ox, oy, hd};
      r.typed = typed;
      r.r = '{sx, sy, ex, ey};
      return r;
   endfunction

   initial begin
      query_type q;
      exit_type  w;
      rows = '{
         // Straight headings from cell (4,5) at scale 16: start (64,80).
         mk(4, 5, 0, 0, 16'h0000, 1, 64, 80, 64, 0),
         mk(4, 5, 0, 0, 16'h8000, 1, 64, 80, 64, 255),
         mk(4, 5, 0, 0, 16'hC000, 1, 64, 80, 0, 80),
         mk(4, 5, 0, 0, 16'h4000, 1, 64, 80, 255, 80),
         // Field extremes; starts at the ends of the range, some outside the box.
         mk(255, 255, 16'hFFFF, 16'hFFFF, 16'h0000, 1, 4095, 4095, 4095, 0),
         mk(0, 0, 0, 0, 16'h8000, 1, 0, 0, 0, 255),
         mk(255, 0, 16'hFFFF, 0, 16'hC000, 1, 4095, 0, 0, 0),
         // Slanted rays, checked by the predictor.
         mk(4, 5, 16'h8000, 16'h8000, 16'h0001, 0),
         mk(4, 5, 16'h8000, 16'h8000, 16'hFFFF, 0),
         mk(4, 5, 0, 0, 16'h3FFF, 0),
         mk(4, 5, 0, 0, 16'h4001, 0),
         mk(4, 5, 0, 0, 16'hBFFF, 0),
         mk(4, 5, 0, 0, 16'hC001, 0),
         mk(4, 5, 0, 0, 16'h7FFF, 0),
         mk(4, 5, 0, 0, 16'h8001, 0),
         mk(4, 5, 0, 0, 16'h2000, 0),
         mk(4, 5, 0, 0, 16'hE000, 0),
         mk(4, 5, 0, 0, 16'h6000, 0),
         mk(4, 5, 0, 0, 16'hA000, 0),
         mk(200, 3, 16'h1234, 16'hFEDC, 16'h1000, 0),
         mk(3, 200, 16'hAAAA, 16'h5555, 16'hD000, 0)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part on the reset registers.
      foreach (rows[i]) begin
         w = rows[i].typed ? rows[i].r : exit_point(rows[i].q);
         send_query(rows[i].q, w);
      end
      drain();

      // Random part over several register settings, extremes included.
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_rect(8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
            1: set_rect(8'd255, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
            2: set_rect(8'd16, 16'd10, 16'd200, 16'd20, 16'd180);
            3: set_rect(8'd0, 16'd5, 16'd250, 16'd5, 16'd250);
            4: set_rect(8'd8, 16'd300, 16'd100, 16'd300, 16'd100); // inverted box
            5: set_rect(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
            default: begin
               set_rect(8'($urandom_range(1, 32)), 16'($urandom_range(0, 64)),
                        16'($urandom_range(64, 600)), 16'($urandom_range(0, 64)),
                        16'($urandom_range(64, 600)));
            end
         endcase
         for (int n = 0; n < 250; n++) begin
            pace();
            q = random_query();
            send_query(q, exit_point(q));
         end
         drain();
      end

      $display("Covered %0d queries over %0d register settings, %0d results checked.",
               sent, cfg_phases, received);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
